/* rtl/core/smbp_pkg.sv */
// ----------------------------------------------------------------------------
// smbp_pkg
// Shared constants and types of the suffix match bit predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package smbp_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int SUFFIX_LEN    = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(SUFFIX_LEN + 1);
    localparam int POS_W         = $clog2(SUFFIX_LEN);

    localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] HASH_SEED = 64'h9e3779b97f4a7c15;

    localparam logic [1:0] CFG_MIN_SEEN     = 2'd0;
    localparam logic [1:0] CFG_MIN_STRENGTH = 2'd1;
    localparam logic [1:0] CFG_STRENGTH_CAP = 2'd2;

    typedef struct packed {
        logic [63:0] key;
        logic [7:0]  nxt;
        logic [7:0]  strength;
        logic [31:0] seen;
    } t_row;

endpackage

`default_nettype wire

/* rtl/core/smbp_in_if.sv */
// ----------------------------------------------------------------------------
// smbp_in_if
// Input channel: one word is a bit query or a completed byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface smbp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] bits;

    modport source (output valid, output op, output bits, input ready);
    modport sink   (input valid, input op, input bits, output ready);
endinterface

`default_nettype wire

/* rtl/core/smbp_out_if.sv */
// ----------------------------------------------------------------------------
// smbp_out_if
// Output channel: one word is a probability with its mixer context.
// ----------------------------------------------------------------------------
`default_nettype none

interface smbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] prob_one;
    logic [5:0] mixer_ctx;
    logic       active;

    modport source (output valid, output prob_one, output mixer_ctx, output active,
                    input ready);
    modport sink   (input valid, input prob_one, input mixer_ctx, input active,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/suffix_match_bit_predictor.sv */
// ----------------------------------------------------------------------------
// suffix_match_bit_predictor
// A bit query word has its result registered and shown in the cycle after it is
// accepted. A byte word reads and rewrites each gathered slot, takes the letter
// step and, for a letter, hashes each suffix of length 2 to 5 with the shared
// 32 by 32 multiplier and looks it up; a final read of the best match, if any,
// and the result follow, and no word is accepted meanwhile. Reset is synchronous;
// after it the table keys are cleared, and no word is accepted during the clear.
// ----------------------------------------------------------------------------
`default_nettype none

module suffix_match_bit_predictor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    smbp_in_if.sink          i_in,
    smbp_out_if.source       o_out
);

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_U_RD   = 4'd2;
    localparam logic [3:0] ST_U_WR   = 4'd3;
    localparam logic [3:0] ST_LET    = 4'd4;
    localparam logic [3:0] ST_H_INIT = 4'd5;
    localparam logic [3:0] ST_H_ACC  = 4'd6;
    localparam logic [3:0] ST_H_X1   = 4'd7;
    localparam logic [3:0] ST_MUL    = 4'd8;
    localparam logic [3:0] ST_H_X2   = 4'd9;
    localparam logic [3:0] ST_H_X3   = 4'd10;
    localparam logic [3:0] ST_LK_RD  = 4'd11;
    localparam logic [3:0] ST_LK_CMP = 4'd12;
    localparam logic [3:0] ST_FIN_RD = 4'd13;
    localparam logic [3:0] ST_FIN    = 4'd14;
    localparam logic [3:0] ST_OUT    = 4'd15;

    localparam int IW = smbp_pkg::IDX_W;
    localparam int CW = smbp_pkg::CNT_W;
    localparam int PW = smbp_pkg::POS_W;
    localparam int SL = smbp_pkg::SUFFIX_LEN;

    smbp_pkg::t_row mem [smbp_pkg::TABLE_ENTRIES];
    smbp_pkg::t_row r_rdata;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    logic [IW-1:0]  mem_raddr;
    smbp_pkg::t_row mem_wdata;

    logic [3:0]     r_st, n_st;
    logic [IW-1:0]  r_clr, n_clr;
    logic [7:0]     r_min_seen, r_min_str;
    logic [6:0]     r_cap;
    logic [7:0]     r_byte, n_byte;
    logic [7:0]     r_let [SL];
    logic [7:0]     n_let [SL];
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [IW-1:0]  r_gs [4];
    logic [IW-1:0]  n_gs [4];
    logic [2:0]     r_gcnt, n_gcnt;
    logic [1:0]     r_gi, n_gi;
    logic           r_match, n_match;
    logic [7:0]     r_exp, n_exp;
    logic [7:0]     r_conf, n_conf;
    logic [4:0]     r_ctx, n_ctx;
    logic [2:0]     r_n, n_n;
    logic [2:0]     r_k, n_k;
    logic [PW-1:0]  r_j, n_j;
    logic [63:0]    r_x, n_x;
    logic [63:0]    r_acc, n_acc;
    logic           r_mno, n_mno;
    logic [1:0]     r_mstep, n_mstep;
    logic [63:0]    r_key, n_key;
    logic           r_found, n_found;
    logic [IW-1:0]  r_best, n_best;
    logic [2:0]     r_bn, n_bn;
    logic           r_ov, n_ov;
    logic [7:0]     r_prob, n_prob;
    logic [5:0]     r_mctx, n_mctx;
    logic           r_act, n_act;

    logic           in_fire;
    logic [31:0]    mul_a, mul_b;
    logic [63:0]    mul_p;
    logic [63:0]    cst;
    logic [63:0]    tmp;
    smbp_pkg::t_row row;
    logic [6:0]     capv;
    logic [2:0]     scls;

    function automatic logic [7:0] f_predict(input logic [7:0] bits, input logic [7:0] expb,
                                             input logic [7:0] conf, input logic on);
        logic [2:0] pos;
        logic [7:0] mask;
        logic [7:0] got;
        logic [7:0] want;
        logic [8:0] inv;
        pos = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (bits[i]) begin
                pos = 3'(i);
            end
        end
        mask = (8'd1 << pos) - 8'd1;
        got  = bits & mask;
        want = expb >> (4'd8 - {1'b0, pos});
        inv  = 9'd256 - {1'b0, conf};
        if (!on) begin
            return 8'd128;
        end
        if (pos != 3'd0 && got != want) begin
            return 8'd128;
        end
        if (expb[3'd7 - pos]) begin
            return conf;
        end
        return inv[7:0];
    endfunction

    assign in_fire     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_st == ST_IDLE) && (!r_ov || o_out.ready);
    assign o_out.valid = r_ov;
    assign o_out.prob_one  = r_prob;
    assign o_out.mixer_ctx = r_mctx;
    assign o_out.active    = r_act;

    assign cst   = r_mno ? smbp_pkg::MIX_C2 : smbp_pkg::MIX_C1;
    assign mul_a = (r_mstep == 2'd2) ? r_x[63:32] : r_x[31:0];
    assign mul_b = (r_mstep == 2'd1) ? cst[63:32] : cst[31:0];
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_comb begin
        n_st = r_st; n_clr = r_clr; n_byte = r_byte; n_let = r_let; n_cnt = r_cnt;
        n_gs = r_gs; n_gcnt = r_gcnt; n_gi = r_gi; n_match = r_match; n_exp = r_exp;
        n_conf = r_conf; n_ctx = r_ctx; n_n = r_n; n_k = r_k; n_j = r_j; n_x = r_x;
        n_acc = r_acc; n_mno = r_mno; n_mstep = r_mstep; n_key = r_key;
        n_found = r_found; n_best = r_best; n_bn = r_bn;
        n_ov = r_ov; n_prob = r_prob; n_mctx = r_mctx; n_act = r_act;
        mem_we = 1'b0; mem_waddr = r_clr; mem_raddr = r_gs[r_gi]; mem_wdata = '0;
        row = r_rdata; tmp = '0; capv = '0; scls = '0;
        if (o_out.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_st)
            ST_CLR: begin
                mem_we = 1'b1;
                n_clr  = r_clr + 1'b1;
                if (r_clr == IW'(smbp_pkg::TABLE_ENTRIES - 1)) begin
                    n_st = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.op) begin
                        n_byte = i_in.bits;
                        n_gi   = 2'd0;
                        n_st   = (r_gcnt == 3'd0) ? ST_LET : ST_U_RD;
                    end else begin
                        n_ov   = 1'b1;
                        n_prob = f_predict(i_in.bits, r_exp, r_conf, r_match);
                        n_mctx = r_match ? 6'd1 + {1'b0, r_ctx} : 6'd0;
                        n_act  = r_match;
                    end
                end
            end
            ST_U_RD: begin
                n_st = ST_U_WR;
            end
            ST_U_WR: begin
                if (row.nxt == r_byte) begin
                    if (row.strength != 8'hff) begin
                        row.strength = row.strength + 8'd1;
                    end
                end else if (row.strength != 8'd0) begin
                    row.strength = row.strength - 8'd1;
                end else begin
                    row.nxt      = r_byte;
                    row.strength = 8'd1;
                end
                if (row.seen != 32'hffffffff) begin
                    row.seen = row.seen + 32'd1;
                end
                mem_we    = 1'b1;
                mem_waddr = r_gs[r_gi];
                mem_wdata = row;
                n_gi      = r_gi + 2'd1;
                n_st      = ({1'b0, r_gi} + 3'd1 < r_gcnt) ? ST_U_RD : ST_LET;
            end
            ST_LET: begin
                n_gcnt = 3'd0;
                if (!((r_byte >= 8'h41 && r_byte <= 8'h5a) ||
                      (r_byte >= 8'h61 && r_byte <= 8'h7a))) begin
                    n_cnt   = '0;
                    n_match = 1'b0;
                    n_st    = ST_OUT;
                end else begin
                    tmp[7:0] = (r_byte <= 8'h5a) ? r_byte + 8'd32 : r_byte;
                    if (r_cnt >= CW'(SL)) begin
                        for (int i = 1; i < SL; i++) begin
                            n_let[i-1] = r_let[i];
                        end
                        n_let[SL-1] = tmp[7:0];
                        n_cnt       = CW'(SL);
                    end else begin
                        n_let[r_cnt[PW-1:0]] = tmp[7:0];
                        n_cnt                = r_cnt + 1'b1;
                    end
                    n_n     = 3'd2;
                    n_found = 1'b0;
                    if (n_cnt < CW'(2)) begin
                        n_match = 1'b0;
                        n_st    = ST_OUT;
                    end else begin
                        n_st = ST_H_INIT;
                    end
                end
            end
            ST_H_INIT: begin
                n_x  = smbp_pkg::HASH_SEED ^ 64'(r_n);
                n_j  = PW'(r_cnt - CW'(r_n));
                n_k  = r_n;
                n_st = ST_H_ACC;
            end
            ST_H_ACC: begin
                n_x  = (r_x << 8) + r_x + 64'(r_let[r_j]);
                n_j  = r_j + 1'b1;
                n_k  = r_k - 3'd1;
                if (r_k == 3'd1) begin
                    n_st = ST_H_X1;
                end
            end
            ST_H_X1: begin
                tmp     = r_x ^ ({61'd0, (r_cnt < CW'(7)) ? r_cnt[2:0] : 3'd7} << 56);
                n_x     = tmp ^ (tmp >> 33);
                n_mno   = 1'b0;
                n_mstep = 2'd0;
                n_st    = ST_MUL;
            end
            ST_MUL: begin
                if (r_mstep == 2'd0) begin
                    n_acc = mul_p;
                end else begin
                    n_acc = r_acc + {mul_p[31:0], 32'd0};
                end
                n_mstep = r_mstep + 2'd1;
                if (r_mstep == 2'd2) begin
                    n_st = r_mno ? ST_H_X3 : ST_H_X2;
                end
            end
            ST_H_X2: begin
                n_x     = r_acc ^ (r_acc >> 33);
                n_mno   = 1'b1;
                n_mstep = 2'd0;
                n_st    = ST_MUL;
            end
            ST_H_X3: begin
                n_key = (r_acc ^ (r_acc >> 33)) | 64'd1;
                n_st  = ST_LK_RD;
            end
            ST_LK_RD: begin
                mem_raddr = r_key[IW-1:0];
                n_st      = ST_LK_CMP;
            end
            ST_LK_CMP: begin
                if (row.key != r_key) begin
                    row       = '0;
                    row.key   = r_key;
                    mem_we    = 1'b1;
                    mem_waddr = r_key[IW-1:0];
                    mem_wdata = row;
                end
                n_gs[r_gcnt[1:0]] = r_key[IW-1:0];
                n_gcnt            = r_gcnt + 3'd1;
                if (row.seen >= 32'(r_min_seen) && row.strength >= r_min_str) begin
                    n_found = 1'b1;
                    n_best  = r_key[IW-1:0];
                    n_bn    = r_n;
                end
                n_n = r_n + 3'd1;
                if (r_n < 3'd5 && CW'(r_n) + 1'b1 <= r_cnt) begin
                    n_st = ST_H_INIT;
                end else if (n_found) begin
                    n_st = ST_FIN_RD;
                end else begin
                    n_match = 1'b0;
                    n_st    = ST_OUT;
                end
            end
            ST_FIN_RD: begin
                mem_raddr = r_best;
                n_st      = ST_FIN;
            end
            ST_FIN: begin
                capv    = (row.strength > 8'(r_cap)) ? r_cap : row.strength[6:0];
                tmp[7:0] = 8'd128 + 8'(capv);
                n_conf  = (tmp[7:0] > 8'd224) ? 8'd224 : tmp[7:0];
                n_exp   = row.nxt;
                scls    = (row.strength[7:3] > 5'd7) ? 3'd7 : row.strength[5:3];
                n_ctx   = {r_bn[1:0] - 2'd2, 3'd0} + {2'd0, scls};
                n_match = 1'b1;
                n_st    = ST_OUT;
            end
            ST_OUT: begin
                n_ov   = 1'b1;
                n_prob = f_predict(8'd1, r_exp, r_conf, r_match);
                n_mctx = r_match ? 6'd1 + {1'b0, r_ctx} : 6'd0;
                n_act  = r_match;
                n_st   = ST_IDLE;
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_CLR;
            r_clr      <= '0;
            r_min_seen <= 8'd3;
            r_min_str  <= 8'd3;
            r_cap      <= 7'd96;
            r_cnt      <= '0;
            r_gcnt     <= '0;
            r_gi       <= '0;
            r_match    <= 1'b0;
            r_exp      <= '0;
            r_conf     <= '0;
            r_ctx      <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_gcnt  <= n_gcnt;
            r_gi    <= n_gi;
            r_match <= n_match;
            r_exp   <= n_exp;
            r_conf  <= n_conf;
            r_ctx   <= n_ctx;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    smbp_pkg::CFG_MIN_SEEN:     r_min_seen <= i_cfg_data;
                    smbp_pkg::CFG_MIN_STRENGTH: r_min_str  <= i_cfg_data;
                    smbp_pkg::CFG_STRENGTH_CAP: r_cap      <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_let   <= n_let;
        r_gs    <= n_gs;
        r_n     <= n_n;
        r_k     <= n_k;
        r_j     <= n_j;
        r_x     <= n_x;
        r_acc   <= n_acc;
        r_mno   <= n_mno;
        r_mstep <= n_mstep;
        r_key   <= n_key;
        r_found <= n_found;
        r_best  <= n_best;
        r_bn    <= n_bn;
        r_prob  <= n_prob;
        r_mctx  <= n_mctx;
        r_act   <= n_act;
    end

endmodule

`default_nettype wire
